// ----- rtl/core/symmetric_epipolar_error_assert.svh -----
// Assertion macros shared by the epipolar error block.
`ifndef SYMMETRIC_EPIPOLAR_ERROR_ASSERT_SVH
`define SYMMETRIC_EPIPOLAR_ERROR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SED_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/sed_pkg.sv -----
package sed_pkg;

  localparam int COORD_FRAC = 4;
  localparam int OUT_FRAC   = 16;
  localparam int ERR_W      = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_COEF   = 9;

  localparam logic [CFG_ADDR_W-1:0] REG_PAIR_01 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAIR_23 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAIR_45 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PAIR_67 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LAST    = 3'd4;

  // Status of one side of the error computation.
  typedef struct packed {
    logic sat;  // quotient does not fit in the output format
    logic deg;  // line normal has zero length
  } div_flag_t;

endpackage

// ----- rtl/core/sed_line.sv -----
// Evaluates p*x + q*y + r*2^COORD_FRAC over two register stages.
module sed_line #(
  parameter int PW = 32,
  parameter int XW = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [PW-1:0]   p_i,
  input  logic signed [PW-1:0]   q_i,
  input  logic signed [PW-1:0]   r_i,
  input  logic signed [XW-1:0]   x_i,
  input  logic signed [XW-1:0]   y_i,
  output logic signed [PW+XW:0]  sum_o
);

  localparam int OW = PW + XW + 1;
  localparam int RW = PW + sed_pkg::COORD_FRAC;

  logic signed [PW+XW-1:0] px_q, qy_q;
  logic signed [RW-1:0]    rs_q;
  logic signed [OW-1:0]    sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= p_i * x_i;
      qy_q  <= q_i * y_i;
      rs_q  <= {r_i, {sed_pkg::COORD_FRAC{1'b0}}};
      sum_q <= OW'(px_q) + OW'(qy_q) + OW'(rs_q);
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- rtl/core/sed_square.sv -----
// Squares a signed value over three stages: magnitude, split partial
// products, and their weighted sum.
module sed_square #(
  parameter int W = 50
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] x_i,
  output logic [2*W-1:0]      sq_o
);

  localparam int LW = W / 2;
  localparam int HW = W - LW;
  localparam int SW = 2 * W;

  logic [W-1:0]       mag_q;
  logic [2*HW-1:0]    hh_q;
  logic [HW+LW-1:0]   hl_q;
  logic [2*LW-1:0]    ll_q;
  logic [SW-1:0]      sq_q;
  logic [HW-1:0]      hi;
  logic [LW-1:0]      lo;

  assign hi = mag_q[W-1:LW];
  assign lo = mag_q[LW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= x_i[W-1] ? W'(-x_i) : W'(x_i);
      hh_q  <= hi * hi;
      hl_q  <= hi * lo;
      ll_q  <= lo * lo;
      sq_q  <= (SW'(hh_q) << (2 * LW)) + (SW'(hl_q) << (LW + 1)) + SW'(ll_q);
    end
  end

  assign sq_o = sq_q;

endmodule

// ----- rtl/core/sed_div.sv -----
// Restoring divider, one quotient bit per stage, with a leading stage that
// scales the dividend and checks for overflow and a zero divisor.
module sed_div #(
  parameter int DSW = 136,
  parameter int NW  = 101
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [DSW-1:0]                      dsq_i,
  input  logic [NW-1:0]                       n_i,
  output logic [sed_pkg::ERR_W-1:0]           q_o,
  output sed_pkg::div_flag_t                  flag_o
);

  localparam int QW  = sed_pkg::ERR_W;
  localparam int SH  = sed_pkg::OUT_FRAC - 2 * sed_pkg::COORD_FRAC;
  localparam int PW  = DSW + SH;
  localparam int NQW = NW + QW + 1;
  localparam int SW  = (PW > NQW) ? PW : NQW;

  logic [SW-1:0]       rem_q [QW+1];
  logic [NW-1:0]       n_q   [QW+1];
  logic [QW-1:0]       quo_q [QW+1];
  sed_pkg::div_flag_t  flg_q [QW+1];

  logic [SW-1:0] p_scaled;
  assign p_scaled = SW'(dsq_i) << SH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]     <= p_scaled;
      n_q[0]       <= n_i;
      quo_q[0]     <= '0;
      flg_q[0].sat <= p_scaled >= (SW'(n_i) << QW);
      flg_q[0].deg <= (n_i == '0);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    logic [SW-1:0] shifted;
    logic          ge;
    assign shifted = SW'(n_q[s]) << B;
    assign ge      = rem_q[s] >= shifted;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? rem_q[s] - shifted : rem_q[s];
        n_q[s+1]   <= n_q[s];
        quo_q[s+1] <= quo_q[s] | (ge ? (QW'(1) << B) : '0);
        flg_q[s+1] <= flg_q[s];
      end
    end
  end

  assign q_o    = quo_q[QW];
  assign flag_o = flg_q[QW];

endmodule

// ----- rtl/core/symmetric_epipolar_error.sv -----
// Throughput: one correspondence per cycle while the output is not stalled; the 32-stage
// quotient pipeline and the split squarers each take a new operand every cycle, so only
// back-pressure on the output stream limits the rate below one.
// Reset (rst_ni low, asynchronous) clears all pipeline valid bits and the nine matrix
// entries to zero; datapath registers are not reset.
`include "symmetric_epipolar_error_assert.svh"

module symmetric_epipolar_error #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port: one register per write, no read-back.
  input  logic                                   cfg_we_i,
  input  logic [sed_pkg::CFG_ADDR_W-1:0]         cfg_addr_i,
  input  logic [sed_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  // Input stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: first_x, first_y, second_x, second_y, zero padding.
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields from bit 0 up: error_value.
  output logic [sed_pkg::ERR_W-1:0]              m_axis_tdata,
  // Fields from bit 0 up: degenerate.
  output logic [0:0]                             m_axis_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int KW  = COEF_WIDTH;
  // Width of a line coefficient (a, b or c) and of the point residual d.
  localparam int AW  = KW + CW + 1;
  localparam int DW  = AW + CW + 1;
  localparam int NW  = 2 * AW + 1;
  // Stage counts: line evaluation, squarer, then the divider with its prep stage.
  localparam int LINE_LAT = 2;
  localparam int SQ_LAT   = 3;
  localparam int DIV_LAT  = sed_pkg::ERR_W + 1;
  localparam int LAT      = LINE_LAT + LINE_LAT + SQ_LAT + DIV_LAT + 1;

  // ---------------------------------------------------------------------------
  // Matrix entries, written through the configuration port. Each 32-bit half of a
  // register contributes its low COEF_WIDTH bits as one signed entry.
  // ---------------------------------------------------------------------------
  logic signed [KW-1:0] coef_q [sed_pkg::NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sed_pkg::NUM_COEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        sed_pkg::REG_PAIR_01: begin
          coef_q[0] <= cfg_wdata_i[KW-1:0];
          coef_q[1] <= cfg_wdata_i[32+KW-1:32];
        end
        sed_pkg::REG_PAIR_23: begin
          coef_q[2] <= cfg_wdata_i[KW-1:0];
          coef_q[3] <= cfg_wdata_i[32+KW-1:32];
        end
        sed_pkg::REG_PAIR_45: begin
          coef_q[4] <= cfg_wdata_i[KW-1:0];
          coef_q[5] <= cfg_wdata_i[32+KW-1:32];
        end
        sed_pkg::REG_PAIR_67: begin
          coef_q[6] <= cfg_wdata_i[KW-1:0];
          coef_q[7] <= cfg_wdata_i[32+KW-1:32];
        end
        sed_pkg::REG_LAST: begin
          coef_q[8] <= cfg_wdata_i[KW-1:0];
        end
        default: begin
          // Indexes beyond the register list are ignored.
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. The whole pipeline advances together; it holds only
  // when a finished result sits at the output and the consumer is not ready, so
  // an idle or draining pipeline keeps accepting a transaction every cycle.
  // ---------------------------------------------------------------------------
  logic           pipe_en;
  logic [LAT-1:0] vld_q, vld_d;

  assign pipe_en       = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign vld_d         = {vld_q[LAT-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= vld_d;
    end
  end

  // Unpack the correspondence.
  logic signed [CW-1:0] x1, y1, x2, y2;
  assign x1 = s_axis_tdata[CW-1:0];
  assign y1 = s_axis_tdata[2*CW-1:CW];
  assign x2 = s_axis_tdata[3*CW-1:2*CW];
  assign y2 = s_axis_tdata[4*CW-1:3*CW];

  // ---------------------------------------------------------------------------
  // Epipolar lines. Side two is the line in the second image taken through the
  // rows of F from the first point; side one is the line in the first image
  // taken through the columns of F from the second point.
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] a2, b2, c2, a1, b1, c1;

  sed_line #(.PW(KW), .XW(CW)) u_line_a2 (
    .clk_i, .en_i(pipe_en), .p_i(coef_q[0]), .q_i(coef_q[1]), .r_i(coef_q[2]),
    .x_i(x1), .y_i(y1), .sum_o(a2)
  );
  sed_line #(.PW(KW), .XW(CW)) u_line_b2 (
    .clk_i, .en_i(pipe_en), .p_i(coef_q[3]), .q_i(coef_q[4]), .r_i(coef_q[5]),
    .x_i(x1), .y_i(y1), .sum_o(b2)
  );
  sed_line #(.PW(KW), .XW(CW)) u_line_c2 (
    .clk_i, .en_i(pipe_en), .p_i(coef_q[6]), .q_i(coef_q[7]), .r_i(coef_q[8]),
    .x_i(x1), .y_i(y1), .sum_o(c2)
  );
  sed_line #(.PW(KW), .XW(CW)) u_line_a1 (
    .clk_i, .en_i(pipe_en), .p_i(coef_q[0]), .q_i(coef_q[3]), .r_i(coef_q[6]),
    .x_i(x2), .y_i(y2), .sum_o(a1)
  );
  sed_line #(.PW(KW), .XW(CW)) u_line_b1 (
    .clk_i, .en_i(pipe_en), .p_i(coef_q[1]), .q_i(coef_q[4]), .r_i(coef_q[7]),
    .x_i(x2), .y_i(y2), .sum_o(b1)
  );
  sed_line #(.PW(KW), .XW(CW)) u_line_c1 (
    .clk_i, .en_i(pipe_en), .p_i(coef_q[2]), .q_i(coef_q[5]), .r_i(coef_q[8]),
    .x_i(x2), .y_i(y2), .sum_o(c1)
  );

  // The coordinates travel alongside the line evaluation so that each residual
  // sees the point of the same transaction.
  logic signed [CW-1:0] x1_q [LINE_LAT];
  logic signed [CW-1:0] y1_q [LINE_LAT];
  logic signed [CW-1:0] x2_q [LINE_LAT];
  logic signed [CW-1:0] y2_q [LINE_LAT];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      x1_q[0] <= x1;
      y1_q[0] <= y1;
      x2_q[0] <= x2;
      y2_q[0] <= y2;
      for (int i = 1; i < LINE_LAT; i++) begin
        x1_q[i] <= x1_q[i-1];
        y1_q[i] <= y1_q[i-1];
        x2_q[i] <= x2_q[i-1];
        y2_q[i] <= y2_q[i-1];
      end
    end
  end

  // Residual of the other point against each line.
  logic signed [DW-1:0] d2, d1;

  sed_line #(.PW(AW), .XW(CW)) u_res_2 (
    .clk_i, .en_i(pipe_en), .p_i(a2), .q_i(b2), .r_i(c2),
    .x_i(x2_q[LINE_LAT-1]), .y_i(y2_q[LINE_LAT-1]), .sum_o(d2)
  );
  sed_line #(.PW(AW), .XW(CW)) u_res_1 (
    .clk_i, .en_i(pipe_en), .p_i(a1), .q_i(b1), .r_i(c1),
    .x_i(x1_q[LINE_LAT-1]), .y_i(y1_q[LINE_LAT-1]), .sum_o(d1)
  );

  // Squared residuals.
  logic [2*DW-1:0] dsq2, dsq1;

  sed_square #(.W(DW)) u_sq_d2 (.clk_i, .en_i(pipe_en), .x_i(d2), .sq_o(dsq2));
  sed_square #(.W(DW)) u_sq_d1 (.clk_i, .en_i(pipe_en), .x_i(d1), .sq_o(dsq1));

  // Squared length of each line normal. The squarers plus the add take one
  // stage fewer than the residual path, so the sum is held one more stage.
  logic [2*AW-1:0] asq2, bsq2, asq1, bsq1;
  logic [NW-1:0]   nrm2_q, nrm1_q, nrm2_dly_q, nrm1_dly_q;

  sed_square #(.W(AW)) u_sq_a2 (.clk_i, .en_i(pipe_en), .x_i(a2), .sq_o(asq2));
  sed_square #(.W(AW)) u_sq_b2 (.clk_i, .en_i(pipe_en), .x_i(b2), .sq_o(bsq2));
  sed_square #(.W(AW)) u_sq_a1 (.clk_i, .en_i(pipe_en), .x_i(a1), .sq_o(asq1));
  sed_square #(.W(AW)) u_sq_b1 (.clk_i, .en_i(pipe_en), .x_i(b1), .sq_o(bsq1));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      nrm2_q     <= NW'(asq2) + NW'(bsq2);
      nrm1_q     <= NW'(asq1) + NW'(bsq1);
      nrm2_dly_q <= nrm2_q;
      nrm1_dly_q <= nrm1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Quotients d^2 / (a^2 + b^2) in Q16.16, one divider per side.
  // ---------------------------------------------------------------------------
  logic [sed_pkg::ERR_W-1:0] quo2, quo1;
  sed_pkg::div_flag_t        flg2, flg1;

  sed_div #(.DSW(2*DW), .NW(NW)) u_div_2 (
    .clk_i, .en_i(pipe_en), .dsq_i(dsq2), .n_i(nrm2_dly_q), .q_o(quo2), .flag_o(flg2)
  );
  sed_div #(.DSW(2*DW), .NW(NW)) u_div_1 (
    .clk_i, .en_i(pipe_en), .dsq_i(dsq1), .n_i(nrm1_dly_q), .q_o(quo1), .flag_o(flg1)
  );

  // ---------------------------------------------------------------------------
  // Output register. A saturated side reads full scale; a degenerate line on
  // either side forces full scale and raises the flag.
  // ---------------------------------------------------------------------------
  logic [sed_pkg::ERR_W-1:0] err2, err1, err_d, err_q;
  logic                      deg_d, deg_q;

  always_comb begin
    err2  = flg2.sat ? '1 : quo2;
    err1  = flg1.sat ? '1 : quo1;
    deg_d = flg2.deg || flg1.deg;
    if (deg_d) begin
      err_d = '1;
    end else begin
      err_d = (err1 > err2) ? err1 : err2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      err_q <= err_d;
      deg_q <= deg_d;
    end
  end

  assign m_axis_tvalid   = vld_q[LAT-1];
  assign m_axis_tdata    = err_q;
  assign m_axis_tuser[0] = deg_q;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `SED_ASSERT_NOW(a_deg_full_scale, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '1)
  `SED_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0])
  `SED_ASSERT_NEXT(a_stall_freezes, !pipe_en, $stable(vld_q))

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the block under test; the defaults of the RTL are used.
  localparam int CW = 16;
  localparam int KW = 32;
  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 1400;

  // One correspondence, as it travels on the input stream.
  typedef struct packed {
    logic signed [CW-1:0] y2;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x1;
  } match_t;

  // One scored correspondence, as it leaves on the output stream.
  typedef struct packed {
    logic        degenerate;
    logic [31:0] err;
  } score_t;

  // A row of the directed table. When check_known is set the expected score
  // is typed in below; otherwise the predictor supplies it.
  typedef struct {
    match_t pt;
    logic   check_known;
    score_t known;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sed_pkg::CFG_ADDR_W-1:0] cfg_addr_i = sed_pkg::REG_PAIR_01;
  logic [sed_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [4*CW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [sed_pkg::ERR_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  symmetric_epipolar_error #(.COORD_WIDTH(CW), .COEF_WIDTH(KW)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The predictor's own copy of the fundamental matrix, row-major.
  logic signed [KW-1:0] fmat [9];

  // Expected scores, oldest first.
  score_t pending_scores[$];
  int     fail_count = 0;
  bit     quiet_phase = 0;   // no idling on either side near the end
  bit     hold_sink = 0;     // long receiver hold-off requested by the sender
  int     idle_cycles = 0;

  // Mirror of a register write in the predictor's matrix copy.
  function automatic void mirror_write(logic [sed_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] val);
    case (idx)
      sed_pkg::REG_PAIR_01, sed_pkg::REG_PAIR_23, sed_pkg::REG_PAIR_45,
      sed_pkg::REG_PAIR_67: begin
        fmat[2*idx]   = val[KW-1:0];
        fmat[2*idx+1] = val[32+KW-1:32];
      end
      sed_pkg::REG_LAST: begin
        fmat[8] = val[KW-1:0];
      end
      default: ;
    endcase
  endfunction

  // Squared distance of (x,y) from the line (a,b,c) in Q16.16, with the
  // degenerate flag for a zero-length normal. Line terms carry 4 fraction
  // bits from the coordinates; c is aligned by shifting left by four.
  function automatic void side_distance(input logic signed [255:0] a, b, c,
                                        input logic signed [255:0] x, y,
                                        output logic [31:0] sq_dist, output bit deg);
    logic signed [255:0] d, n, p;
    d = a * x + b * y + (c <<< sed_pkg::COORD_FRAC);
    n = a * a + b * b;
    deg = (n == 0);
    if (deg) begin
      sq_dist = '1;
    end else begin
      p = (d * d) <<< (sed_pkg::OUT_FRAC - 2 * sed_pkg::COORD_FRAC);
      if (p >= (n <<< 32)) sq_dist = '1;
      else sq_dist = 32'(p / n);
    end
  endfunction

  // Symmetric epipolar error of one correspondence against the current matrix.
  function automatic score_t score_match(match_t m);
    logic signed [255:0] f [9];
    logic signed [255:0] x1, y1, x2, y2, a, b, c;
    logic [31:0] e1, e2;
    bit d1, d2;
    score_t s;
    foreach (f[i]) f[i] = fmat[i];
    x1 = m.x1; y1 = m.y1; x2 = m.x2; y2 = m.y2;
    // Line in the second image through F, point two measured against it.
    a = f[0] * x1 + f[1] * y1 + (f[2] <<< sed_pkg::COORD_FRAC);
    b = f[3] * x1 + f[4] * y1 + (f[5] <<< sed_pkg::COORD_FRAC);
    c = f[6] * x1 + f[7] * y1 + (f[8] <<< sed_pkg::COORD_FRAC);
    side_distance(a, b, c, x2, y2, e2, d2);
    // Line in the first image through F transposed.
    a = f[0] * x2 + f[3] * y2 + (f[6] <<< sed_pkg::COORD_FRAC);
    b = f[1] * x2 + f[4] * y2 + (f[7] <<< sed_pkg::COORD_FRAC);
    c = f[2] * x2 + f[5] * y2 + (f[8] <<< sed_pkg::COORD_FRAC);
    side_distance(a, b, c, x1, y1, e1, d1);
    s.degenerate = d1 | d2;
    s.err = s.degenerate ? 32'hFFFF_FFFF : (e1 > e2 ? e1 : e2);
    return s;
  endfunction

  // Register write while the block is idle.
  task automatic write_reg(logic [sed_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    mirror_write(idx, val);
  endtask

  task automatic load_matrix(logic [31:0] e [9]);
    write_reg(sed_pkg::REG_PAIR_01, {e[1], e[0]});
    write_reg(sed_pkg::REG_PAIR_23, {e[3], e[2]});
    write_reg(sed_pkg::REG_PAIR_45, {e[5], e[4]});
    write_reg(sed_pkg::REG_PAIR_67, {e[7], e[6]});
    write_reg(sed_pkg::REG_LAST, {32'h0, e[8]});
    cfg_we_i <= 1'b0;
  endtask

  // Offer one correspondence and hold it until the block takes it. The
  // expectation is queued at the accepting edge, before any result can come.
  task automatic send_match(match_t m, bit check_known, score_t known);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_scores.push_back(check_known ? known : score_match(m));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic match_t random_match(bit full_range);
    match_t m;
    if (full_range) begin
      m = {$urandom, $urandom};
    end else begin
      // Realistic image coordinates up to about 512 pixels.
      m.x1 = $signed($urandom_range(0, 16383)) - 8192;
      m.y1 = $signed($urandom_range(0, 16383)) - 8192;
      m.x2 = $signed($urandom_range(0, 16383)) - 8192;
      m.y2 = $signed($urandom_range(0, 16383)) - 8192;
    end
    return m;
  endfunction

  // Receiver: random back-pressure bursts, plus one long hold-off.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_sink = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Output checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result err=%h deg=%b", $time, m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        if (m_axis_tdata !== want.err) begin
          $display("%0t: error_value expected %h actual %h", $time, want.err, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                   m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("symmetric_epipolar_error verification failed");
      $finish;
    end
  end

  localparam logic [31:0] ONE_HALF = 32'h4000_0000;
  localparam logic [31:0] MAX_POS  = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_NEG  = 32'h8000_0000;
  localparam score_t DEG_SCORE = '{degenerate: 1'b1, err: 32'hFFFF_FFFF};
  localparam score_t ZERO_SCORE = '{degenerate: 1'b0, err: 32'h0};

  initial begin
    vector_t directed [$];
    logic [31:0] mat [9];
    vector_t v;
    int n;
    foreach (fmat[i]) fmat[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the matrix is zero, so every line is degenerate.
    send_match('{x1: 16'h7FFF, y1: 16'h8000, x2: 16'h0000, y2: 16'hFFFF}, 1, DEG_SCORE);
    send_match('0, 1, DEG_SCORE);
    drain();

    // Pure-translation style matrix [0 0 0; 0 0 -h; 0 h 0]: the distance is
    // the vertical offset, so equal y gives zero error.
    mat = '{0, 0, 0, 0, 0, -ONE_HALF, 0, ONE_HALF, 0};
    load_matrix(mat);
    directed.push_back('{'{x1: 16'sd160, y1: 16'sd320, x2: -16'sd800, y2: 16'sd320},
                        1, ZERO_SCORE});
    directed.push_back('{'{x1: 16'h7FFF, y1: 16'h7FFF, x2: 16'h8000, y2: 16'h7FFF},
                        1, ZERO_SCORE});
    directed.push_back('{'{x1: 0, y1: 0, x2: 0, y2: 16'sd16}, 0, ZERO_SCORE});
    directed.push_back('{'{x1: 0, y1: 16'h8000, x2: 0, y2: 16'h7FFF}, 0, ZERO_SCORE});
    directed.push_back('{'{x1: 16'h8000, y1: 16'h8000, x2: 16'h8000, y2: 16'h8000},
                        1, ZERO_SCORE});
    foreach (directed[i]) send_match(directed[i].pt, directed[i].check_known,
                                     directed[i].known);
    drain();

    // Extreme entries, and a matrix whose first line degenerates only at the origin.
    mat = '{MAX_NEG, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG};
    load_matrix(mat);
    for (int i = 0; i < 8; i++) begin
      v.pt = {$urandom, $urandom};
      if (i == 0) v.pt = '{x1: 16'h7FFF, y1: 16'h7FFF, x2: 16'h7FFF, y2: 16'h7FFF};
      if (i == 1) v.pt = '{x1: 16'h8000, y1: 16'h8000, x2: 16'h8000, y2: 16'h8000};
      send_match(v.pt, 0, ZERO_SCORE);
    end
    drain();
    // No constant term in the first two rows: the normal of the line in the
    // second image vanishes exactly when the first point is the origin.
    mat = '{ONE_HALF, 0, 0, 0, ONE_HALF, 0, ONE_HALF, ONE_HALF, MAX_POS};
    load_matrix(mat);
    send_match('0, 1, DEG_SCORE);
    send_match('{x1: 16'sd16, y1: 0, x2: 0, y2: 0}, 0, ZERO_SCORE);
    send_match('{x1: 16'sd16, y1: -16'sd16, x2: 16'sd1, y2: 16'sd3}, 0, ZERO_SCORE);
    drain();

    // Random part: several matrices, each with a batch of mostly realistic correspondences.
    n = 0;
    for (int phase = 0; n < NUM_RANDOM; phase++) begin
      foreach (mat[i]) begin
        case ($urandom_range(0, 3))
          0: mat[i] = $urandom;
          1: mat[i] = $signed($urandom_range(0, 2000)) - 1000;
          2: mat[i] = $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
          default: mat[i] = $signed($urandom) >>> $urandom_range(4, 24);
        endcase
      end
      load_matrix(mat);
      if (phase == 1) hold_sink = 1;
      if (n > NUM_RANDOM - 150) quiet_phase = 1;
      repeat (100) begin
        send_match(random_match($urandom_range(0, 3) == 0), 0, ZERO_SCORE);
        n++;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("symmetric_epipolar_error verification clean");
    end else begin
      $display("symmetric_epipolar_error verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sed_pkg.sv
rtl/core/sed_line.sv
rtl/core/sed_square.sv
rtl/core/sed_div.sv
rtl/core/symmetric_epipolar_error.sv
test/tb.sv
